/* rtl/ved_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, status codes and elaboration-time table functions for the debiased
// variance estimate core. No dependencies.
package ved_pkg;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  localparam int TABLE_SEGMENTS_DEF = 64;
  localparam logic [63:0] CF_DEPTH = 64'd200;
  localparam logic [63:0] SERIES_MAX = 64'd300;
  localparam logic [63:0] SQRT_HALF_PI_Q24 = 64'd21027122;
  localparam logic [24:0] RATIO_EIGHT = 25'd524288;

  // Unsigned 64-bit quotient by long division, used only while building the table.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], n[k]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_k(input logic [63:0] e);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = e >> 24;
    lo = e & 64'hFF_FFFF;
    return hi * SQRT_HALF_PI_Q24 + ((lo * SQRT_HALF_PI_Q24) >> 24);
  endfunction

  function automatic logic [63:0] exp_half_sq(input logic [63:0] u, input logic [63:0] nseg);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    term = 64'd1 << 24;
    sum = term;
    for (n = 64'd1; n <= SERIES_MAX && term != 64'd0; n++) begin
      term = udiv(term * u, nseg);
      term = udiv(term * u, 64'd2 * nseg * n);
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] odd_series(input logic [63:0] u, input logic [63:0] nseg);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    term = udiv(u << 24, nseg);
    sum = term;
    for (n = 64'd1; n <= SERIES_MAX && term != 64'd0; n++) begin
      term = udiv(term * u, nseg);
      term = udiv(term * u, nseg * (64'd2 * n + 64'd1));
      sum = sum + term;
    end
    return sum;
  endfunction

  // Knot value of phi/Phi in Q24 at x = a / nseg.
  function automatic logic [63:0] knot_value(input longint a, input longint nseg);
    logic [63:0] un;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] j;
    logic [63:0] u;
    logic [63:0] q;
    logic [63:0] sr;
    un = 64'(nseg);
    if (a >= 6 * nseg) return 64'd0;
    if (a <= -2 * nseg) begin
      s = udiv(64'(-a) << 24, un);
      c = s;
      for (j = CF_DEPTH; j >= 64'd1; j--) c = s + udiv(j << 48, c);
      return c;
    end
    u = (a < 0) ? 64'(-a) : 64'(a);
    q = mul_k(exp_half_sq(u, un));
    sr = odd_series(u, un);
    if (a >= 0) q = q + sr;
    else q = (q > sr) ? q - sr : 64'd0;
    if (q == 64'd0) q = 64'd1;
    return udiv(64'd1 << 48, q);
  endfunction

endpackage

/* rtl/variance_estimate_debias_core.sv */
`timescale 1ns / 1ps
// Top level of the debiased variance estimate core: a fixed-latency arithmetic pipeline
// with an output skid stage. Depends on ved_pkg.
//
// The core accepts one beat per clock while s_tready is high and returns one result beat
// per input beat, in order. The latency is set by the digit-serial stages: a 62-step
// restoring divider for 2^61/count, a 31-step square root, a 24-step ratio divider and a
// 30-step divider for the far negative tail, one quotient or root bit per stage. The whole
// pipeline holds while two results wait at the output, and s_tready goes low only then.
// Status on m_tuser is 0 for a normal result, 1 when both variances are zero and 2 when
// the result saturated at all ones.
module variance_estimate_debias_core #(
  parameter int TABLE_SEGMENTS = ved_pkg::TABLE_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // between_variance [31:0], noise_variance [63:32], group_count [79:64]
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // debiased_estimate [31:0]
  output logic [31:0] m_tdata,
  // status [1:0]
  output logic [1:0]  m_tuser
);

  localparam int JW = $clog2(TABLE_SEGMENTS + 1);
  localparam int PW = 21 + JW;

  localparam int DivFirst  = 1;
  localparam int DivLast   = 62;
  localparam int TsqLast   = 24;
  localparam int SsqFirst  = 63;
  localparam int SsqLast   = 93;
  localparam int SeStg     = 94;
  localparam int ProdStg   = 95;
  localparam int RdivFirst = 96;
  localparam int RdivLast  = 119;
  localparam int PosStg    = 120;
  localparam int ReadStg   = 121;
  localparam int SlopeStg  = 122;
  localparam int InterpStg = 123;
  localparam int CorrStg   = 124;
  localparam int SumStg    = 125;
  localparam int AdivFirst = 121;
  localparam int AdivLast  = 150;
  localparam int LastStg   = 151;

  typedef struct packed {
    logic              zero;
    logic              neg;
    logic              asym;
    logic              hzero;
    logic              jlast;
    logic              up;
    logic [31:0]       m;
    logic [31:0]       mag;
    logic [15:0]       g;
    logic [61:0]       dq;
    logic [16:0]       drem;
    logic [47:0]       tr_rad;
    logic [23:0]       tr_root;
    logic [25:0]       tr_rem;
    logic [61:0]       sr_rad;
    logic [30:0]       sr_root;
    logic [32:0]       sr_rem;
    logic [32:0]       se;
    logic [55:0]       prod;
    logic [23:0]       rq;
    logic [32:0]       rrem;
    logic [JW-1:0]     jidx;
    logic [19:0]       frac;
    logic [31:0]       h0;
    logic [31:0]       h1;
    logic [31:0]       h;
    logic [51:0]       lp;
    logic [40:0]       corr;
    logic [41:0]       res;
    logic [48:0]       anum;
    logic [24:0]       arem;
    logic [29:0]       aq;
    logic [31:0]       outv;
    ved_pkg::status_t  outs;
  } item_t;

  logic [31:0] htab [0:TABLE_SEGMENTS];

  for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_knot
    localparam logic [31:0] KnotVal = 32'(ved_pkg::knot_value(
        longint'(16 * k - 8 * TABLE_SEGMENTS), longint'(TABLE_SEGMENTS)));
    assign htab[k] = KnotVal;
  end

  item_t            pipe [0:LastStg];
  logic [LastStg:0] vld;
  item_t            in_rec;
  logic             en;
  logic             push;
  logic             skid_valid;
  logic [31:0]      skid_data;
  ved_pkg::status_t skid_stat;
  ved_pkg::status_t out_stat;
  logic [31:0]      b_in;
  logic [31:0]      v_in;
  logic [15:0]      g_in;

  assign en = !skid_valid;
  assign s_tready = en;
  assign push = en && vld[LastStg];
  assign m_tuser = out_stat;

  assign b_in = s_tdata[31:0];
  assign v_in = s_tdata[63:32];
  assign g_in = s_tdata[79:64];

  always_comb begin
    in_rec = '0;
    in_rec.zero = (b_in == 32'd0) && (v_in == 32'd0);
    in_rec.neg = b_in < v_in;
    in_rec.m = in_rec.neg ? v_in : b_in;
    in_rec.mag = in_rec.neg ? (v_in - b_in) : (b_in - v_in);
    in_rec.g = (g_in == 16'd0) ? 16'd1 : g_in;
    in_rec.tr_rad = {1'b0, in_rec.g, 31'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LastStg-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= in_rec;
    end
  end

  for (genvar i = 1; i <= LastStg; i++) begin : g_stg
    localparam int RBit = (i >= RdivFirst && i <= RdivLast) ? RdivLast - i : 0;
    localparam int ABit = (i >= AdivFirst && i <= AdivLast) ? AdivLast - i : 0;
    item_t nxt;

    always_comb begin
      logic [16:0] drs;
      logic [27:0] trs;
      logic [27:0] ttr;
      logic [34:0] srs;
      logic [34:0] str;
      logic [32:0] rrs;
      logic [24:0] ars;
      logic [24:0] pos;
      logic [PW-1:0] pp;
      logic [JW:0] jj;
      logic [31:0] diff;
      logic [62:0] p63;
      logic [64:0] cp;
      logic [41:0] val;
      drs = '0;
      trs = '0;
      ttr = '0;
      srs = '0;
      str = '0;
      rrs = '0;
      ars = '0;
      pos = '0;
      pp = '0;
      jj = '0;
      diff = '0;
      p63 = '0;
      cp = '0;
      val = '0;
      nxt = pipe[i-1];
      if (i >= DivFirst && i <= DivLast) begin
        drs = {pipe[i-1].drem[15:0], 1'(i == DivFirst)};
        if (drs >= {1'b0, pipe[i-1].g}) begin
          nxt.drem = drs - {1'b0, pipe[i-1].g};
          nxt.dq = {pipe[i-1].dq[60:0], 1'b1};
        end else begin
          nxt.drem = drs;
          nxt.dq = {pipe[i-1].dq[60:0], 1'b0};
        end
        if (i == DivLast) begin
          nxt.sr_rad = nxt.dq;
        end
      end
      if (i >= DivFirst && i <= TsqLast) begin
        trs = {pipe[i-1].tr_rem, pipe[i-1].tr_rad[47:46]};
        ttr = {2'b00, pipe[i-1].tr_root, 2'b01};
        nxt.tr_rad = {pipe[i-1].tr_rad[45:0], 2'b00};
        if (trs >= ttr) begin
          nxt.tr_rem = 26'(trs - ttr);
          nxt.tr_root = {pipe[i-1].tr_root[22:0], 1'b1};
        end else begin
          nxt.tr_rem = 26'(trs);
          nxt.tr_root = {pipe[i-1].tr_root[22:0], 1'b0};
        end
      end
      if (i >= SsqFirst && i <= SsqLast) begin
        srs = {pipe[i-1].sr_rem, pipe[i-1].sr_rad[61:60]};
        str = {2'b00, pipe[i-1].sr_root, 2'b01};
        nxt.sr_rad = {pipe[i-1].sr_rad[59:0], 2'b00};
        if (srs >= str) begin
          nxt.sr_rem = 33'(srs - str);
          nxt.sr_root = {pipe[i-1].sr_root[29:0], 1'b1};
        end else begin
          nxt.sr_rem = 33'(srs);
          nxt.sr_root = {pipe[i-1].sr_root[29:0], 1'b0};
        end
      end
      if (i == SeStg) begin
        p63 = 63'(pipe[i-1].m) * 63'(pipe[i-1].sr_root);
        nxt.se = p63[62:30];
      end
      if (i == ProdStg) begin
        nxt.prod = 56'(pipe[i-1].mag) * 56'(pipe[i-1].tr_root);
        nxt.rrem = {1'b0, nxt.prod[55:24]};
      end
      if (i >= RdivFirst && i <= RdivLast) begin
        rrs = {pipe[i-1].rrem[31:0], pipe[i-1].prod[RBit]};
        if (rrs >= {1'b0, pipe[i-1].m}) begin
          nxt.rrem = rrs - {1'b0, pipe[i-1].m};
          nxt.rq = {pipe[i-1].rq[22:0], 1'b1};
        end else begin
          nxt.rrem = rrs;
          nxt.rq = {pipe[i-1].rq[22:0], 1'b0};
        end
      end
      if (i == PosStg) begin
        pos = pipe[i-1].neg ? (ved_pkg::RATIO_EIGHT - 25'(pipe[i-1].rq))
                            : (ved_pkg::RATIO_EIGHT + 25'(pipe[i-1].rq));
        pp = PW'(pos[20:0]) * PW'(TABLE_SEGMENTS);
        jj = pp[PW-1:20];
        nxt.jlast = jj >= (JW+1)'(TABLE_SEGMENTS);
        nxt.jidx = nxt.jlast ? JW'(TABLE_SEGMENTS) : jj[JW-1:0];
        nxt.frac = pp[19:0];
        nxt.asym = pipe[i-1].neg && (25'(pipe[i-1].rq) > ved_pkg::RATIO_EIGHT);
        nxt.hzero = !pipe[i-1].neg && (25'(pipe[i-1].rq) >= ved_pkg::RATIO_EIGHT);
        nxt.anum = {pipe[i-1].se, 16'd0};
        nxt.arem = 25'(pipe[i-1].se[32:14]);
        nxt.aq = '0;
      end
      if (i == ReadStg) begin
        nxt.h0 = htab[pipe[i-1].jidx];
        nxt.h1 = pipe[i-1].jlast ? htab[pipe[i-1].jidx] : htab[JW'(pipe[i-1].jidx + 1'b1)];
      end
      if (i == SlopeStg) begin
        nxt.up = pipe[i-1].h1 >= pipe[i-1].h0;
        diff = nxt.up ? (pipe[i-1].h1 - pipe[i-1].h0) : (pipe[i-1].h0 - pipe[i-1].h1);
        nxt.lp = 52'(diff) * 52'(pipe[i-1].frac);
      end
      if (i == InterpStg) begin
        if (pipe[i-1].hzero) begin
          nxt.h = '0;
        end else if (pipe[i-1].up) begin
          nxt.h = pipe[i-1].h0 + pipe[i-1].lp[51:20];
        end else begin
          nxt.h = pipe[i-1].h0 - pipe[i-1].lp[51:20];
        end
      end
      if (i == CorrStg) begin
        cp = 65'(pipe[i-1].se) * 65'(pipe[i-1].h);
        nxt.corr = cp[64:24];
      end
      if (i == SumStg) begin
        if (!pipe[i-1].neg) begin
          nxt.res = 42'(pipe[i-1].corr) + 42'(pipe[i-1].mag);
        end else if (pipe[i-1].corr >= 41'(pipe[i-1].mag)) begin
          nxt.res = 42'(pipe[i-1].corr - 41'(pipe[i-1].mag));
        end else begin
          nxt.res = '0;
        end
      end
      if (i >= AdivFirst && i <= AdivLast) begin
        ars = {pipe[i-1].arem[23:0], pipe[i-1].anum[ABit]};
        if (ars >= {1'b0, pipe[i-1].rq}) begin
          nxt.arem = ars - {1'b0, pipe[i-1].rq};
          nxt.aq = {pipe[i-1].aq[28:0], 1'b1};
        end else begin
          nxt.arem = ars;
          nxt.aq = {pipe[i-1].aq[28:0], 1'b0};
        end
      end
      if (i == LastStg) begin
        val = pipe[i-1].asym ? 42'(pipe[i-1].aq) : pipe[i-1].res;
        if (pipe[i-1].zero) begin
          nxt.outv = '0;
          nxt.outs = ved_pkg::STAT_ZERO;
        end else if (|val[41:32]) begin
          nxt.outv = '1;
          nxt.outs = ved_pkg::STAT_SAT;
        end else begin
          nxt.outv = val[31:0];
          nxt.outs = ved_pkg::STAT_OK;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        out_stat <= skid_stat;
      end else if (push) begin
        m_tdata <= pipe[LastStg].outv;
        out_stat <= pipe[LastStg].outs;
      end
    end else if (push) begin
      skid_data <= pipe[LastStg].outv;
      skid_stat <= pipe[LastStg].outs;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a beat while the output register is empty");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved while stalled");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ved_pkg::STAT_ZERO) |-> (m_tdata == 32'd0))
    else $error("zero-variance status with a nonzero result");

  a_sat_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ved_pkg::STAT_SAT) |-> (m_tdata == 32'hFFFF_FFFF))
    else $error("saturation status without a saturated result");

endmodule

/* tb/sv/variance_estimate_debias_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for variance_estimate_debias_core: random and directed beats are
// compared against an in-bench predictor of the debiased estimate. Depends on ved_pkg.
module variance_estimate_debias_core_tb;

  localparam int NSEG = 64;

  typedef struct packed {
    logic [31:0]      estimate;
    ved_pkg::status_t stat;
  } debiased_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  debiased_t   pending_estimates[$];
  logic [63:0] ratio_table[0:NSEG];
  int          error_count = 0;
  bit          stall_free = 1'b0;

  always #4 clk = ~clk;

  variance_estimate_debias_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] exp_sq(input logic [63:0] u);
    logic [63:0] term;
    logic [63:0] acc;
    term = 64'd1 << 24;
    acc = term;
    for (int n = 1; n <= 300 && term != 0; n++) begin
      term = term * u / NSEG;
      term = term * u / (64'(2 * NSEG * n));
      acc += term;
    end
    return acc;
  endfunction

  function automatic logic [63:0] odd_sum(input logic [63:0] u);
    logic [63:0] term;
    logic [63:0] acc;
    term = (u << 24) / NSEG;
    acc = term;
    for (int n = 1; n <= 300 && term != 0; n++) begin
      term = term * u / NSEG;
      term = term * u / (64'(NSEG * (2 * n + 1)));
      acc += term;
    end
    return acc;
  endfunction

  function automatic logic [63:0] knot(input longint a);
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] u;
    logic [63:0] e;
    logic [63:0] q;
    logic [63:0] sr;
    if (a >= 6 * NSEG) return 0;
    if (a <= -2 * NSEG) begin
      s = (64'(-a) << 24) / NSEG;
      c = s;
      for (longint j = 200; j >= 1; j--) c = s + ((64'(j) << 48) / c);
      return c;
    end
    u = (a < 0) ? 64'(-a) : 64'(a);
    e = exp_sq(u);
    q = (e >> 24) * 64'd21027122 + (((e & 64'hFF_FFFF) * 64'd21027122) >> 24);
    sr = odd_sum(u);
    if (a >= 0) q = q + sr;
    else q = (q > sr) ? q - sr : 0;
    if (q == 0) q = 1;
    return (64'd1 << 48) / q;
  endfunction

  function automatic logic [63:0] density_ratio(input logic [63:0] pos);
    logic [63:0] p;
    logic [63:0] j;
    logic [63:0] f;
    p = pos * NSEG;
    j = p >> 20;
    f = p & 64'hF_FFFF;
    if (j >= NSEG) return ratio_table[NSEG];
    if (ratio_table[j+1] >= ratio_table[j])
      return ratio_table[j] + (((ratio_table[j+1] - ratio_table[j]) * f) >> 20);
    return ratio_table[j] - (((ratio_table[j] - ratio_table[j+1]) * f) >> 20);
  endfunction

  function automatic debiased_t predict_estimate(input logic [31:0] b, input logic [31:0] v,
                                                 input logic [15:0] cnt);
    debiased_t   r;
    logic [63:0] g;
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] rmag;
    logic [63:0] se;
    logic [63:0] res;
    logic [63:0] h;
    logic [63:0] corr;
    logic        neg;
    g = (cnt == 0) ? 64'd1 : 64'(cnt);
    if (b == 0 && v == 0) begin
      r.estimate = 0;
      r.stat = ved_pkg::STAT_ZERO;
      return r;
    end
    neg = b < v;
    m = neg ? 64'(v) : 64'(b);
    mag = neg ? 64'(v - b) : 64'(b - v);
    rmag = mag * root64(g << 31) / m;
    se = (m * root64((64'd1 << 61) / g)) >> 30;
    if (neg && rmag > 64'(ved_pkg::RATIO_EIGHT)) begin
      res = (se << 16) / rmag;
    end else begin
      if (!neg && rmag >= 64'(ved_pkg::RATIO_EIGHT)) h = 0;
      else h = density_ratio(neg ? 64'(ved_pkg::RATIO_EIGHT) - rmag
                                 : 64'(ved_pkg::RATIO_EIGHT) + rmag);
      corr = (se * h) >> 24;
      if (neg) res = (corr >= mag) ? corr - mag : 0;
      else res = mag + corr;
    end
    if (res > 64'hFFFF_FFFF) begin
      r.estimate = 32'hFFFF_FFFF;
      r.stat = ved_pkg::STAT_SAT;
    end else begin
      r.estimate = res[31:0];
      r.stat = ved_pkg::STAT_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  task automatic send_variances(input logic [31:0] b, input logic [31:0] v,
                                input logic [15:0] cnt);
    int gap;
    gap = stall_free ? 0 : $urandom_range(19);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cnt, v, b};
    pending_estimates.push_back(predict_estimate(b, v, cnt));
    do @(posedge clk); while (!s_tready);
  endtask

  always @(posedge clk) begin
    debiased_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h/%0d", m_tdata, m_tuser));
      end else begin
        exp_r = pending_estimates.pop_front();
        if (m_tdata !== exp_r.estimate)
          report_mismatch($sformatf("estimate %h, want %h", m_tdata, exp_r.estimate));
        if (m_tuser !== exp_r.stat)
          report_mismatch($sformatf("status %0d, want %0d", m_tuser, exp_r.stat));
      end
    end
  end

  initial begin
    int wait_cycles;
    @(posedge clk);
    forever begin
      wait_cycles = stall_free ? 0 : $urandom_range(19);
      if (wait_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic test_corner_values();
    send_variances(0, 0, 1);
    send_variances(0, 0, 0);
    send_variances(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_variances(32'hFFFF_FFFF, 0, 1);
    send_variances(0, 32'hFFFF_FFFF, 1);
    send_variances(32'hFFFF_FFFF, 32'h8000_0000, 0);
    send_variances(32'h0001_0000, 32'h0001_0000, 10);
    send_variances(32'h0001_0000, 32'h0002_0000, 16'hFFFF);
    send_variances(1, 32'h0010_0000, 50);
    send_variances(32'h0002_0000, 32'h0001_0000, 2);
    send_variances(32'h0010_0000, 1, 16'hFFFF);
    send_variances(32'h0001_0000, 32'h0001_8000, 3);
    send_variances(32'hF000_0000, 32'hFFFF_FFFF, 1);
    send_variances(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
    send_variances(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
  endtask

  task automatic test_random_variances(input int count);
    logic [31:0] b;
    logic [31:0] v;
    logic [15:0] cnt;
    for (int i = 0; i < count; i++) begin
      stall_free = ((i / 100) % 4 == 3);
      b = $urandom;
      cnt = (i % 5 == 0) ? 16'($urandom) : 16'($urandom_range(1, 64));
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = b + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        2: v = b >> $urandom_range(0, 8);
        default: begin
          v = b;
          b = b >> $urandom_range(0, 16);
        end
      endcase
      if (i % 7 == 0) b = b >> $urandom_range(0, 31);
      send_variances(b, v, cnt);
    end
    stall_free = 1'b0;
  endtask

  initial begin
    for (int k = 0; k <= NSEG; k++) ratio_table[k] = knot(longint'(16 * k - 8 * NSEG));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_values();
    test_random_variances(935);
    s_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("[variance_estimate_debias_core] OK");
    else $display("[variance_estimate_debias_core] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[variance_estimate_debias_core] ERROR");
    $finish;
  end
endmodule

/* variance_estimate_debias_core.f */
rtl/ved_pkg.sv
rtl/variance_estimate_debias_core.sv
tb/sv/variance_estimate_debias_core_tb.sv
